[design/llars_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llars_pkg
// Shared types and constants for the life-like automaton row step block.
// ----------------------------------------------------------------------------
package llars_pkg;

  localparam int GW_W     = 7;
  localparam int RULE_W   = 4;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH   = 4;
  localparam int QCNT_W   = 3;

  localparam logic [GW_W-1:0]   GRID_WIDTH_RST   = 7'd64;
  localparam logic [RULE_W-1:0] SURVIVE_LOW_RST  = 4'd3;
  localparam logic [RULE_W-1:0] SURVIVE_HIGH_RST = 4'd6;
  localparam logic [RULE_W-1:0] BIRTH_COUNT_RST  = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_SURVIVE_LOW  = 2'd1,
    CFG_SURVIVE_HIGH = 2'd2,
    CFG_BIRTH_COUNT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RULE_W-1:0] survive_low;
    logic [RULE_W-1:0] survive_high;
    logic [RULE_W-1:0] birth_count;
  } rule_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

[design/life_like_automaton_row_step_top.sv]
`timescale 1ns / 1ps
// each result row is written into a registered output queue when its item is accepted
// throughput: one item per cycle unless stalled, all columns computed by parallel cell lanes
// the last row of a grid yields two results (one if it is the first row), pushed together
// into a four-entry output queue; input stalls only when that queue lacks room for two
// reset: synchronous active low, rules return to 3/6/4, width to 64, no rows held
// ----------------------------------------------------------------------------
// life_like_automaton_row_step_top
// One generation of a life-like automaton over a row-streamed grid.
// ----------------------------------------------------------------------------
module life_like_automaton_row_step_top #(
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [llars_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [llars_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [MAX_COLS-1:0]             in_row,
  input  logic                            in_last_row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [MAX_COLS-1:0]             out_next_row,
  output logic                            out_last
);

  logic [llars_pkg::GW_W-1:0] grid_width_r;
  llars_pkg::rule_t           rule_r;
  logic [MAX_COLS-1:0]        above_r;
  logic [MAX_COLS-1:0]        mid_r;
  logic                       held_r;
  logic [MAX_COLS-1:0]        mask;
  logic [MAX_COLS-1:0]        row_m;
  logic [MAX_COLS-1:0]        a_mid;
  logic [MAX_COLS-1:0]        a_down;
  logic [MAX_COLS-1:0]        row_a;
  logic [MAX_COLS-1:0]        row_b;
  logic                       room2;
  logic                       in_fire;
  llars_pkg::push_t           push;

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    localparam logic [llars_pkg::GW_W-1:0] ColIdx = (llars_pkg::GW_W)'(c);
    assign mask[c] = (ColIdx < grid_width_r);
  end

  assign in_ready    = room2;
  assign in_fire     = in_valid && in_ready;
  assign row_m       = in_row & mask;
  assign a_mid       = held_r ? mid_r : row_m;
  assign a_down      = held_r ? row_m : '0;
  assign push.first  = in_fire && (held_r || in_last_row);
  assign push.second = in_fire && held_r && in_last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= llars_pkg::GRID_WIDTH_RST;
      rule_r       <= '{survive_low:  llars_pkg::SURVIVE_LOW_RST,
                        survive_high: llars_pkg::SURVIVE_HIGH_RST,
                        birth_count:  llars_pkg::BIRTH_COUNT_RST};
      above_r      <= '0;
      mid_r        <= '0;
      held_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          llars_pkg::CFG_GRID_WIDTH:   grid_width_r        <= cfg_wdata;
          llars_pkg::CFG_SURVIVE_LOW:  rule_r.survive_low  <= cfg_wdata[llars_pkg::RULE_W-1:0];
          llars_pkg::CFG_SURVIVE_HIGH: rule_r.survive_high <= cfg_wdata[llars_pkg::RULE_W-1:0];
          llars_pkg::CFG_BIRTH_COUNT:  rule_r.birth_count  <= cfg_wdata[llars_pkg::RULE_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (in_last_row) begin
          above_r <= '0;
          mid_r   <= '0;
          held_r  <= 1'b0;
        end else begin
          above_r <= mid_r;
          mid_r   <= row_m;
          held_r  <= 1'b1;
        end
      end
    end
  end

  llars_row #(.COLS(MAX_COLS)) u_row_a (
    .up       (above_r),
    .mid      (a_mid),
    .down     (a_down),
    .mask     (mask),
    .rule     (rule_r),
    .next_row (row_a)
  );

  llars_row #(.COLS(MAX_COLS)) u_row_b (
    .up       (mid_r),
    .mid      (row_m),
    .down     ('0),
    .mask     (mask),
    .rule     (rule_r),
    .next_row (row_b)
  );

  llars_queue #(.COLS(MAX_COLS)) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .row_a        (row_a),
    .last_a       (!held_r),
    .row_b        (row_b),
    .room2        (room2),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_next_row (out_next_row),
    .out_last     (out_last)
  );

endmodule

[design/llars_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llars_cell
// One cell lane: counts live neighbors and applies the survive/birth rule.
// ----------------------------------------------------------------------------
module llars_cell (
  input  logic [7:0]       nbr,
  input  logic             alive,
  input  llars_pkg::rule_t rule,
  output logic             nxt
);

  logic [llars_pkg::RULE_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {{(llars_pkg::RULE_W-1){1'b0}}, nbr[i]};
    end
  end

  assign nxt = alive ? ((cnt >= rule.survive_low) && (cnt <= rule.survive_high))
                     : (cnt == rule.birth_count);

endmodule

[design/llars_row.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llars_row
// Row of parallel cell lanes computing the next generation of the middle row.
// ----------------------------------------------------------------------------
module llars_row #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0]  up,
  input  logic [COLS-1:0]  mid,
  input  logic [COLS-1:0]  down,
  input  logic [COLS-1:0]  mask,
  input  llars_pkg::rule_t rule,
  output logic [COLS-1:0]  next_row
);

  logic [COLS+1:0] up_p;
  logic [COLS+1:0] md_p;
  logic [COLS+1:0] dn_p;

  assign up_p = {1'b0, up & mask, 1'b0};
  assign md_p = {1'b0, mid & mask, 1'b0};
  assign dn_p = {1'b0, down & mask, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic nxt;

    llars_cell u_cell (
      .nbr   ({up_p[c], up_p[c+1], up_p[c+2], md_p[c], md_p[c+2],
               dn_p[c], dn_p[c+1], dn_p[c+2]}),
      .alive (md_p[c+1]),
      .rule  (rule),
      .nxt   (nxt)
    );

    assign next_row[c] = nxt & mask[c];
  end

endmodule

[design/llars_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llars_queue
// Merging stage: collects up to two result rows per item into a short queue.
// ----------------------------------------------------------------------------
module llars_queue #(
  parameter int COLS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  llars_pkg::push_t push,
  input  logic [COLS-1:0]  row_a,
  input  logic             last_a,
  input  logic [COLS-1:0]  row_b,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [COLS-1:0]  out_next_row,
  output logic             out_last
);

  localparam int D = llars_pkg::QDEPTH;
  localparam int CW = llars_pkg::QCNT_W;

  logic [COLS-1:0] q_row_r [D];
  logic [COLS-1:0] q_row_nxt [D];
  logic [D-1:0]    q_last_r;
  logic [D-1:0]    q_last_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic [CW-1:0]   base;
  logic            pop;

  assign out_valid    = (cnt_r != '0);
  assign out_next_row = q_row_r[0];
  assign out_last     = q_last_r[0];
  assign room2        = (cnt_r <= CW'(D - 2));
  assign pop          = out_valid && out_ready;
  assign base         = cnt_r - {{(CW-1){1'b0}}, pop};

  always_comb begin
    for (int i = 0; i < D; i++) begin
      if (pop && (i < D - 1)) begin
        q_row_nxt[i]  = q_row_r[(i < D - 1) ? i + 1 : i];
        q_last_nxt[i] = q_last_r[(i < D - 1) ? i + 1 : i];
      end else begin
        q_row_nxt[i]  = q_row_r[i];
        q_last_nxt[i] = q_last_r[i];
      end
      if (push.first && (base == CW'(i))) begin
        q_row_nxt[i]  = row_a;
        q_last_nxt[i] = last_a;
      end
      if (push.second && ((base + CW'(1)) == CW'(i))) begin
        q_row_nxt[i]  = row_b;
        q_last_nxt[i] = 1'b1;
      end
    end
    cnt_nxt = base + {{(CW-1){1'b0}}, push.first} + {{(CW-1){1'b0}}, push.second};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_row_r  <= q_row_nxt;
    q_last_r <= q_last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(D))
    else $error("queue count above depth");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second result without first");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.first |-> room2)
    else $error("item pushed without room for two results");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) && !push.first |=> (cnt_r == '0))
    else $error("queue count moved without a push");
`endif

endmodule
